>>> sv/sitoa_pkg.sv
// shared types, constants and the power-of-ten table for the integer to decimal text core
// no dependencies
package sitoa_pkg;

    localparam int unsigned C_NUM_POS     = 10;   // decimal positions of a 32-bit magnitude
    localparam int unsigned C_QUEUE_DEPTH = 2;

    localparam logic [5:0] C_CHAR_ZERO  = 6'd48;
    localparam logic [5:0] C_CHAR_MINUS = 6'd45;

    // multiples k * 10^p, k and p in 0..9; 9 * 10^9 needs 34 bits
    typedef logic [9:0][9:0][33:0] t_mult_tab;

    // one queued conversion: sign, magnitude, position of the leading digit
    typedef struct packed {
        logic        neg;
        logic [31:0] mag;
        logic [3:0]  top;
    } t_job;

    function automatic t_mult_tab f_mult_tab();
        t_mult_tab   tab;
        logic [33:0] pw;
        pw = 34'd1;
        for (int i = 0; i < 10; i++) begin
            for (int k = 0; k < 10; k++) begin
                tab[i][k] = 34'(34'(k) * pw);
            end
            pw = 34'(pw * 34'd10);
        end
        return tab;
    endfunction

    localparam t_mult_tab C_MULT = f_mult_tab();

endpackage

>>> sv/sitoa_front.sv
// front part: takes an integer, forms sign and magnitude, finds the leading digit position
// depends on sitoa_pkg
module sitoa_front
    import sitoa_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    output logic               o_push,
    output t_job               o_job,
    input  logic               i_full
);

    logic        r_vld;
    logic        r_neg;
    logic [31:0] r_mag;
    logic        n_vld;
    logic [31:0] n_mag;
    logic [31:0] w_raw;
    logic [3:0]  w_top;
    logic        w_accept;

    assign o_stall  = r_vld & i_full;
    assign w_accept = i_valid & ~o_stall;
    assign o_push   = r_vld & ~i_full;
    assign w_raw    = $unsigned(i_value);
    assign n_mag    = w_raw[31] ? (32'd0 - w_raw) : w_raw;

    always_comb begin
        n_vld = r_vld;
        if (w_accept) begin
            n_vld = 1'b1;
        end else if (o_push) begin
            n_vld = 1'b0;
        end
    end

    // leading digit position: how many of 10^1..10^9 the magnitude reaches
    always_comb begin
        w_top = 4'd0;
        for (int p = 1; p < 10; p++) begin
            w_top = w_top + {3'b000, ({2'b00, r_mag} >= C_MULT[p][1])};
        end
    end

    assign o_job = '{neg: r_neg, mag: r_mag, top: w_top};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg <= w_raw[31];
            r_mag <= n_mag;
        end
    end

endmodule

>>> sv/sitoa_queue.sv
// short job queue between front and back parts
// depends on sitoa_pkg
module sitoa_queue
    import sitoa_pkg::*;
#(
    parameter int unsigned DEPTH = C_QUEUE_DEPTH   // 2 or more
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_job             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign w_push  = i_push & ~o_full;
    assign w_pop   = i_pop & ~o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

>>> sv/sitoa_back.sv
// back part: emits the sign and then one decimal digit per cycle while the output is not stalled, leading digit first
// depends on sitoa_pkg
module sitoa_back
    import sitoa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [5:0] o_ascii_char,
    output logic       o_last_char
);

    logic        r_busy;
    logic        r_neg_pend;
    logic [31:0] r_mag;
    logic [3:0]  r_pos;
    logic        r_out_vld;
    logic [5:0]  r_char;
    logic        r_last;
    logic        w_adv;
    logic [3:0]  w_digit;
    logic [31:0] w_rem;

    assign o_pop = ~r_busy & ~i_empty;
    assign w_adv = r_busy & (~r_out_vld | ~i_stall);

    // digit at the current position: largest k with k * 10^p not above the magnitude
    always_comb begin
        w_digit = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if ({2'b00, r_mag} >= C_MULT[r_pos][k]) begin
                w_digit = 4'(k);
            end
        end
        w_rem = r_mag - C_MULT[r_pos][w_digit][31:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
            end else if (w_adv && !r_neg_pend && r_pos == 4'd0) begin
                r_busy <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_neg_pend <= i_job.neg;
            r_mag      <= i_job.mag;
            r_pos      <= i_job.top;
        end else if (w_adv) begin
            if (r_neg_pend) begin
                r_neg_pend <= 1'b0;
            end else begin
                r_mag <= w_rem;
                r_pos <= r_pos - 4'd1;
            end
        end
        if (w_adv) begin
            if (r_neg_pend) begin
                r_char <= C_CHAR_MINUS;
                r_last <= 1'b0;
            end else begin
                r_char <= C_CHAR_ZERO + {2'b00, w_digit};
                r_last <= (r_pos == 4'd0);
            end
        end
    end

    assign o_valid      = r_out_vld;
    assign o_ascii_char = r_char;
    assign o_last_char  = r_last;

endmodule

>>> sv/signed_int_to_decimal_ascii_core.sv
// top level of the signed 32-bit integer to decimal text core
// depends on sitoa_pkg, sitoa_front, sitoa_queue, sitoa_back
//
// usage:
//   input channel i_valid / o_stall / i_value carries one signed 32-bit integer per item
//   output channel o_valid / i_stall / o_ascii_char / o_last_char carries one character
//   per item: an optional '-' then the decimal digits, leading digit first, no leading
//   zeros; zero gives a single '0'; o_last_char marks the final digit of a number
//   the most negative value gives "-2147483648", eleven characters
// an accepted integer passes the front register, the queue and the digit unit registers in order
// throughput: one character per cycle while a number is being emitted and the receiver
//   does not stall, with a load step for each next number into the digit unit;
//   the digit unit (one power-of-ten compare bank stepping down the positions) sets this
// the front part forms sign, magnitude and leading digit position and hands them to a
//   short queue, so new integers are taken while earlier ones are still being emitted
// reset (synchronous, active low) empties the front stage, the queue and the output
//   register; partly emitted numbers are dropped
// when the receiver stalls the output character holds; the digit unit waits, the queue
//   fills, and then o_stall rises toward the sender
module signed_int_to_decimal_ascii_core
    import sitoa_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = C_QUEUE_DEPTH
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [5:0]         o_ascii_char,
    output logic               o_last_char
);

    // front to queue
    logic w_push;
    t_job w_push_job;
    logic w_full;

    // queue to back
    logic w_pop;
    t_job w_pop_job;
    logic w_empty;

    sitoa_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_value (i_value),
        .o_push  (w_push),
        .o_job   (w_push_job),
        .i_full  (w_full)
    );

    sitoa_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_push_job),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_job   (w_pop_job),
        .o_empty (w_empty)
    );

    // sign first, then one digit per cycle whenever the output register is free
    sitoa_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job        (w_pop_job),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

endmodule

>>> tb/signed_int_to_decimal_ascii_core_test.sv
`timescale 1ns / 100ps
// testbench for signed_int_to_decimal_ascii_core: directed table then random integers,
// every output character checked against typed text or an in-bench decimal text predictor
// depends on sitoa_pkg and signed_int_to_decimal_ascii_core
module signed_int_to_decimal_ascii_core_test;
    import sitoa_pkg::*;

    // one expected output character
    typedef struct {
        logic [5:0] ascii;
        logic       last;
    } t_char_item;

    localparam int DIR_ROWS    = 21;
    localparam int RAND_ITEMS  = 240;
    localparam int SETTLE_CYC  = 20;

    // directed rows: extremes, zero, sign and digit count boundaries, alternating bits
    localparam logic signed [31:0] DIR_VALUE [DIR_ROWS] = '{
        32'sd0,
        32'sd1,
        -32'sd1,
        32'sh7fffffff,
        32'sh80000000,
        32'sh80000001,
        32'sd9,
        32'sd10,
        -32'sd9,
        -32'sd10,
        32'sd99,
        32'sd100,
        32'sd999999999,
        32'sd1000000000,
        -32'sd1000000000,
        -32'sd999999999,
        32'sh55555555,
        32'shaaaaaaaa,
        32'sd1234567890,
        -32'sd1234567890,
        32'sd7
    };

    // expected text typed in where it reads straight off the value, empty means predicted
    string dir_text [DIR_ROWS] = '{
        "0",
        "",
        "-1",
        "2147483647",
        "-2147483648",
        "",
        "9",
        "10",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        "",
        ""
    };

    logic               i_clk;
    logic               i_rst_n  = 1'b0;
    logic               i_valid  = 1'b0;
    logic               o_stall;
    logic signed [31:0] i_value  = '0;
    logic               o_valid;
    logic               i_stall  = 1'b0;
    logic [5:0]         o_ascii_char;
    logic               o_last_char;

    t_char_item expected_chars [$];
    int         error_count = 0;
    bit         allow_idle  = 1'b0;

    signed_int_to_decimal_ascii_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last_char  (o_last_char)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // hard stop well beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t mismatch: %s", $realtime, what);
        error_count++;
    endtask

    // decimal text of a signed 32-bit value: optional minus, then digits msd first
    function automatic void predict_decimal_text(input logic signed [31:0] value);
        logic [31:0] raw;
        logic [31:0] mag;
        logic [3:0]  digit [10];
        int          count;
        raw   = value;
        // magnitude taken as unsigned, so the most negative value still works
        mag   = raw[31] ? 32'd0 - raw : raw;
        count = 0;
        do begin
            digit[count] = 4'(mag % 32'd10);
            mag          = mag / 32'd10;
            count++;
        end while (mag != 0 && count < 10);
        if (raw[31])
            expected_chars.push_back('{ascii: C_CHAR_MINUS, last: 1'b0});
        for (int d = count - 1; d >= 0; d--)
            expected_chars.push_back('{ascii: C_CHAR_ZERO + 6'(digit[d]), last: d == 0});
    endfunction

    function automatic void push_typed_text(input string text);
        for (int i = 0; i < text.len(); i++)
            expected_chars.push_back('{ascii: 6'(text[i]), last: i == text.len() - 1});
    endfunction

    // random value: mostly a random digit count and sign, some corners, some raw words
    function automatic logic signed [31:0] random_value();
        logic [63:0] wide;
        logic [63:0] lim;
        logic [63:0] mag;
        logic [31:0] pw;
        int unsigned ndig;
        bit          neg;
        neg = $urandom_range(0, 1);
        case ($urandom_range(0, 9))
            0: begin
                return $urandom();
            end
            1: begin
                // near a power of ten, either sign
                pw = 32'd1;
                repeat ($urandom_range(0, 9)) pw = pw * 32'd10;
                pw = pw + 32'($urandom_range(0, 2)) - 32'd1;
                return neg ? 32'd0 - pw : pw;
            end
            2: begin
                case ($urandom_range(0, 3))
                    0: return 32'sh80000000;
                    1: return 32'sh7fffffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            default: begin
                ndig = $urandom_range(1, 10);
                lim  = 64'd1;
                repeat (ndig) lim = lim * 64'd10;
                // ten digits: stay inside the 32-bit range on each side
                if (ndig == 10)
                    lim = neg ? 64'd2147483649 : 64'd2147483648;
                wide = {$urandom(), $urandom()};
                mag  = wide % lim;
                return neg ? 32'd0 - mag[31:0] : mag[31:0];
            end
        endcase
    endfunction

    // present one integer and hold it until the core takes it
    task automatic send_value(input logic signed [31:0] value, input string text);
        i_valid <= 1'b1;
        i_value <= value;
        do @(posedge i_clk); while (o_stall);
        if (text.len() != 0)
            push_typed_text(text);
        else
            predict_decimal_text(value);
    endtask

    task automatic maybe_gap();
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
    endtask

    // sender goes quiet until every character in flight has come out
    task automatic hold_until_drained();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (expected_chars.size() != 0);
    endtask

    // receiver: check each accepted character, then pick the next stall level
    initial begin : receiver
        int         stall_left;
        t_char_item want;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && !i_stall) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected char %0d last %0b",
                                              o_ascii_char, o_last_char));
                end else begin
                    want = expected_chars.pop_front();
                    if (o_ascii_char !== want.ascii)
                        report_mismatch($sformatf("ascii_char %0d, wanted %0d",
                                                  o_ascii_char, want.ascii));
                    if (o_last_char !== want.last)
                        report_mismatch($sformatf("last_char %0b, wanted %0b on char %0d",
                                                  o_last_char, want.last, want.ascii));
                end
            end
            // stall bursts start at random, only while idling is allowed
            if (stall_left > 0)
                stall_left--;
            else if (allow_idle && $urandom_range(0, 9) == 0)
                stall_left = $urandom_range(1, 13);
            i_stall <= stall_left > 0;
        end
    end

    initial begin : stimulus
        repeat (11) @(posedge i_clk);
        i_rst_n    <= 1'b1;
        allow_idle = 1'b1;

        // directed table
        for (int row = 0; row < DIR_ROWS; row++) begin
            send_value(DIR_VALUE[row], dir_text[row]);
            maybe_gap();
        end
        hold_until_drained();

        // random part: idling on, then a quiet stretch, then on again, quiet at the end
        for (int n = 0; n < RAND_ITEMS; n++) begin
            allow_idle = (n < 100) || (n >= 140 && n < 190);
            if (n == 100)
                hold_until_drained();
            send_value(random_value(), "");
            maybe_gap();
        end

        i_valid <= 1'b0;
        while (expected_chars.size() != 0) @(posedge i_clk);
        // keep the clock running a while longer so stray characters show up
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
